// File: rtl/core/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared types, constants and tables for the pilot phase tracker.
// ----------------------------------------------------------------------------
package ppt_pkg;

    localparam int MAX_STREAMS_DEF  = 4;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int SAMPLE_W   = 16;
    localparam int PHASE_W    = 16;
    localparam int CORDIC_W   = 27;
    localparam int ATAN_LEN   = 24;
    localparam int ATAN_IDX_W = 5;
    localparam int BIN_W      = 6;
    localparam int WORD_W     = 2 * SAMPLE_W;

    localparam logic signed [PHASE_W-1:0] PI_Q      = 16'sd8192;
    localparam logic signed [PHASE_W-1:0] HALF_PI_Q = 16'sd4096;
    localparam logic signed [PHASE_W-1:0] TWO_PI_Q  = 16'sd16384;

    localparam int SPAN        = 14;
    localparam int DIV_SHIFT   = 24;
    localparam int DIV_RECIP   = (1 << DIV_SHIFT) / SPAN;
    localparam int POL_LEN     = 127;
    localparam int POL_SHIFT   = 16;
    localparam int POL_RECIP   = (1 << POL_SHIFT) / POL_LEN;
    localparam int GAIN_Q15    = 19898;

    localparam logic [BIN_W-1:0] FIRST_BIN = 6'd1;
    localparam logic [BIN_W-1:0] GAP_LAST  = 6'd28;
    localparam logic [BIN_W-1:0] GAP_NEXT  = 6'd36;
    localparam logic [BIN_W-1:0] LAST_BIN  = 6'd63;

    // atan(2^-i) scaled so that pi = 8192
    localparam logic [11:0] ATAN_TAB [ATAN_LEN] = '{
        12'd2048, 12'd1209, 12'd639, 12'd324, 12'd163, 12'd81, 12'd41, 12'd20,
        12'd10, 12'd5, 12'd3, 12'd1, 12'd1, 12'd0, 12'd0, 12'd0,
        12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0
    };

    // polarity sequence, index 0 leftmost
    localparam logic [0:126] POLARITY = {
        10'b1111000100, 10'b0011010011, 10'b0110111111,
        10'b0111011001, 10'b1101000101, 10'b0010011111,
        10'b0011001010, 10'b1100011000, 10'b0100101111,
        10'b0101010000, 10'b0101101011, 10'b1001000111,
        7'b0000000
    };

    // pilot pattern sign (1 = negative), indexed {streams-1, row, column}
    localparam logic [0:63] PATTERN_NEG = {
        16'b0001_0001_0001_0001,
        16'b0011_0110_0110_0110,
        16'b0011_0101_0110_0110,
        16'b0001_0010_0100_1000
    };

    typedef struct packed {
        logic        valid;
        logic [1:0]  stream;
        logic [15:0] sym;
    } ppt_job_t;

    typedef struct packed {
        logic             pop;
        logic             busy;
        logic [BIN_W-1:0] rd_addr;
    } ppt_back_req_t;

    function automatic logic [BIN_W-1:0] pilot_bin(input logic [1:0] l);
        logic [BIN_W-1:0] b;
        unique case (l)
            2'd0:    b = 6'd43;
            2'd1:    b = 6'd57;
            2'd2:    b = 6'd7;
            default: b = 6'd21;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/ppt_in_if.sv
// ----------------------------------------------------------------------------
// ppt_in_if
// Input bin channel: valid/ready handshake with one FFT bin per item.
// ----------------------------------------------------------------------------
interface ppt_in_if import ppt_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 stream;
    logic [BIN_W-1:0]           bin;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
    logic [15:0]                symbol_number;

    modport source (output valid, stream, bin, sample_re, sample_im, symbol_number,
                    input ready);
    modport sink   (input valid, stream, bin, sample_re, sample_im, symbol_number,
                    output ready);
endinterface

// File: rtl/core/ppt_out_if.sv
// ----------------------------------------------------------------------------
// ppt_out_if
// Output channel: valid/ready handshake with one corrected bin per item.
// ----------------------------------------------------------------------------
interface ppt_out_if import ppt_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 out_stream;
    logic [BIN_W-1:0]           out_bin;
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
    logic                       last;

    modport source (output valid, out_stream, out_bin, out_re, out_im, last, input ready);
    modport sink   (input valid, out_stream, out_bin, out_re, out_im, last, output ready);
endinterface

// File: rtl/core/ofdm_pilot_phase_tracker_core.sv
// ----------------------------------------------------------------------------
// ofdm_pilot_phase_tracker_core
// Residual phase tracking on the four pilots of one stream of an OFDM symbol.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one FFT bin per item, bins 0..63 of one stream in order. Bin 63
//            closes the symbol and queues it for correction.
//   out_ch : 56 corrected bins per symbol (1-28, 36-63), last set on bin 63.
//   cfg    : cfg_wr_en/cfg_wr_data load num_streams (reset value 1); write
//            only while the block is idle.
// Timing:
//   Bins are taken one per cycle while no symbol is queued or in correction.
//   After bin 63 the input holds off until the last corrected bin has entered
//   the output register; the buffer is shared. Pilot estimation vectors each
//   nonzero pilot in turn, then the bins are derotated one at a time, both on
//   the single shared iterative CORDIC, which runs one micro-rotation per cycle.
// Reset:
//   Clears control state, the per-stream phase history and num_streams to 1.
//   The bin buffer holds garbage until written.
// Stall:
//   A stalled output holds its item; the sequencer waits on the next result.
// ----------------------------------------------------------------------------
module ofdm_pilot_phase_tracker_core import ppt_pkg::*;
#(
    parameter int MAX_STREAMS  = MAX_STREAMS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ppt_in_if.sink     in_ch,
    ppt_out_if.source  out_ch,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data
);

    logic [2:0]        num_streams_reg;
    ppt_job_t          job;
    ppt_back_req_t     req;
    logic [WORD_W-1:0] rd_data;

    // hold the stream count; it only selects the pilot pattern table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_streams_reg <= 3'd1;
        end
        else if (cfg_wr_en)
        begin
            num_streams_reg <= cfg_wr_data;
        end
    end

    // front: buffer bins, queue the symbol job
    ppt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .req(req), .job(job), .rd_data(rd_data)
    );

    // back: estimate, unwrap, interpolate, derotate
    ppt_back #(
        .MAX_STREAMS(MAX_STREAMS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .req(req), .rd_data(rd_data),
        .num_streams(num_streams_reg), .out_ch(out_ch)
    );

endmodule

// File: rtl/core/ppt_front.sv
// ----------------------------------------------------------------------------
// ppt_front
// Accepts bins into the symbol buffer and queues a job on bin 63.
// ----------------------------------------------------------------------------
module ppt_front import ppt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    ppt_in_if.sink        in_ch,
    input  ppt_back_req_t req,
    output ppt_job_t      job,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [64];
    logic [WORD_W-1:0] rd_data_reg;
    logic              job_valid_reg;
    logic [1:0]        job_stream_reg;
    logic [15:0]       job_sym_reg;
    logic              accept;

    // stall while a job waits or the back end still reads the buffer
    assign in_ch.ready = !job_valid_reg && !req.busy;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[in_ch.bin] <= {in_ch.sample_re, in_ch.sample_im};
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (accept && in_ch.bin == LAST_BIN)
        begin
            job_valid_reg <= 1'b1;
        end
        else if (req.pop)
        begin
            job_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_ch.bin == LAST_BIN)
        begin
            job_stream_reg <= in_ch.stream;
            job_sym_reg    <= in_ch.symbol_number;
        end
    end

    assign job.valid  = job_valid_reg;
    assign job.stream = job_stream_reg;
    assign job.sym    = job_sym_reg;
    assign rd_data    = rd_data_reg;

endmodule

// File: rtl/core/ppt_cordic.sv
// ----------------------------------------------------------------------------
// ppt_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module ppt_cordic import ppt_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       vec_mode,
    input  logic signed [CORDIC_W-1:0] x_in,
    input  logic signed [CORDIC_W-1:0] y_in,
    input  logic signed [PHASE_W-1:0]  z_in,
    output logic                       done,
    output logic signed [CORDIC_W-1:0] x_out,
    output logic signed [CORDIC_W-1:0] y_out,
    output logic signed [PHASE_W-1:0]  z_out
);

    localparam int I_W = $clog2(CORDIC_STEPS);

    logic signed [CORDIC_W-1:0] x_reg, y_reg;
    logic signed [PHASE_W-1:0]  z_reg;
    logic [I_W-1:0]             i_reg;
    logic                       run_reg, done_reg, mode_reg;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [PHASE_W-1:0]  at;
    logic                       sub_x;

    assign dx    = y_reg >>> i_reg;
    assign dy    = x_reg >>> i_reg;
    assign at    = $signed({4'b0, ATAN_TAB[ATAN_IDX_W'(i_reg)]});
    assign sub_x = mode_reg ? !(y_reg > 0) : (z_reg >= 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            if (start)
            begin
                run_reg  <= 1'b1;
                done_reg <= 1'b0;
                i_reg    <= '0;
            end
            else if (run_reg)
            begin
                if (i_reg == I_W'(CORDIC_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                    i_reg    <= i_reg + 1'b1;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
            mode_reg <= vec_mode;
        end
        else if (run_reg)
        begin
            if (sub_x)
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
            else
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
        end
    end

    assign done  = done_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: rtl/core/ppt_back.sv
// ----------------------------------------------------------------------------
// ppt_back
// Pilot phase estimate, unwrap, interpolation and per-bin derotation.
// ----------------------------------------------------------------------------
module ppt_back import ppt_pkg::*;
#(
    parameter int MAX_STREAMS  = MAX_STREAMS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  ppt_job_t          job,
    output ppt_back_req_t     req,
    input  logic [WORD_W-1:0] rd_data,
    input  logic [2:0]        num_streams,
    ppt_out_if.source         out_ch
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_POL    = 4'd1;
    localparam logic [3:0] ST_RD_PIL = 4'd2;
    localparam logic [3:0] ST_VEC    = 4'd3;
    localparam logic [3:0] ST_VEC_RUN= 4'd4;
    localparam logic [3:0] ST_UNWRAP = 4'd5;
    localparam logic [3:0] ST_RD_BIN = 4'd6;
    localparam logic [3:0] ST_MUL    = 4'd7;
    localparam logic [3:0] ST_DIV    = 4'd8;
    localparam logic [3:0] ST_FIX    = 4'd9;
    localparam logic [3:0] ST_ROT    = 4'd10;
    localparam logic [3:0] ST_GAIN   = 4'd11;
    localparam logic [3:0] ST_OUT    = 4'd12;

    localparam logic [2:0] MAX_N = 3'(MAX_STREAMS);

    logic [3:0]  state_reg, state_next;
    logic [1:0]  stream_reg;
    logic [15:0] sym_reg;
    logic [1:0]  n_idx_reg, row_reg, l_reg;
    logic        pol_neg_reg;
    logic [BIN_W-1:0] m_reg;
    logic signed [PHASE_W-1:0] raw_reg [4];
    logic signed [PHASE_W-1:0] ph_reg [4];
    logic signed [PHASE_W-1:0] hist_reg [4][4];
    logic signed [SAMPLE_W-1:0] smp_re_reg, smp_im_reg;
    logic signed [22:0] num_reg;
    logic signed [PHASE_W-1:0] base_reg;
    logic [21:0] div_a_reg;
    logic [17:0] div_q_reg;
    logic        neg_reg;
    logic signed [SAMPLE_W-1:0] res_re_reg, res_im_reg;
    logic        out_valid_reg, out_last_reg;
    logic [1:0]  out_stream_reg;
    logic [BIN_W-1:0] out_bin_reg;
    logic signed [SAMPLE_W-1:0] out_re_reg, out_im_reg;

    // cordic
    logic cor_start, cor_vec, cor_done;
    logic signed [CORDIC_W-1:0] cor_x_in, cor_y_in, cor_x, cor_y;
    logic signed [PHASE_W-1:0]  cor_z_in, cor_z;

    ppt_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .start(cor_start), .vec_mode(cor_vec),
        .x_in(cor_x_in), .y_in(cor_y_in), .z_in(cor_z_in),
        .done(cor_done), .x_out(cor_x), .y_out(cor_y), .z_out(cor_z)
    );

    // polarity index: (sym + 2) mod 127 by reciprocal with one correction; num_streams clamped to 1..MAX_STREAMS
    logic [16:0] pv;
    logic [26:0] pprod;
    logic [10:0] pq;
    logic [16:0] pr0, pr;
    logic [2:0]  n_cl;
    always_comb
    begin
        pv    = {1'b0, sym_reg} + 17'd2;
        pprod = 27'(pv) * 27'(POL_RECIP);
        pq    = pprod[POL_SHIFT +: 11];
        pr0   = pv - (17'({pq, 7'b0}) - 17'(pq));
        pr    = (pr0 >= 17'(POL_LEN)) ? pr0 - 17'(POL_LEN) : pr0;
        n_cl  = num_streams;
        if (n_cl == 3'd0)
        begin
            n_cl = 3'd1;
        end
        if (n_cl > MAX_N)
        begin
            n_cl = MAX_N;
        end
    end

    // vectoring setup for pilot l
    logic signed [SAMPLE_W-1:0] rd_re, rd_im;
    logic s_neg;
    logic [1:0] col;
    logic signed [CORDIC_W-1:0] vx0, vy0;
    logic zero_vec;
    always_comb
    begin
        rd_re    = rd_data[WORD_W-1:SAMPLE_W];
        rd_im    = rd_data[SAMPLE_W-1:0];
        col      = sym_reg[1:0] + l_reg;
        s_neg    = PATTERN_NEG[{n_idx_reg, row_reg, col}] ^ pol_neg_reg;
        vx0      = CORDIC_W'(rd_re) <<< 8;
        vy0      = CORDIC_W'(rd_im) <<< 8;
        if (s_neg)
        begin
            vx0 = -vx0;
            vy0 = -vy0;
        end
        zero_vec = (rd_re == 0) && (rd_im == 0);
    end

    // unwrap
    logic trans;
    logic signed [PHASE_W-1:0] unw [4];
    always_comb
    begin
        trans = !((raw_reg[0] > 0 && raw_reg[1] > 0 && raw_reg[2] > 0 && raw_reg[3] > 0) ||
                  (raw_reg[0] < 0 && raw_reg[1] < 0 && raw_reg[2] < 0 && raw_reg[3] < 0));
        for (int l = 0; l < 4; l++)
        begin
            unw[l] = raw_reg[l];
            if (trans && hist_reg[stream_reg][l] > HALF_PI_Q && raw_reg[l] < -HALF_PI_Q)
            begin
                unw[l] = raw_reg[l] + TWO_PI_Q;
            end
            else if (trans && hist_reg[stream_reg][l] < -HALF_PI_Q && raw_reg[l] > HALF_PI_Q)
            begin
                unw[l] = raw_reg[l] - TWO_PI_Q;
            end
        end
    end

    // interpolation segment select; ph order is 43, 57, 7, 21
    logic signed [7:0]  mk;
    logic signed [5:0]  d;
    logic signed [16:0] diff;
    logic signed [PHASE_W-1:0] base;
    logic signed [16:0] d75, d217, d5743;
    always_comb
    begin
        mk    = $signed({2'b0, m_reg});
        d75   = 17'(ph_reg[2]) - 17'(ph_reg[1]);
        d217  = 17'(ph_reg[3]) - 17'(ph_reg[2]);
        d5743 = 17'(ph_reg[1]) - 17'(ph_reg[0]);
        base  = ph_reg[1];
        d     = '0;
        diff  = '0;
        if (m_reg > 6'd57)
        begin
            d = 6'(mk - 8'sd57); diff = d75;
        end
        else if (m_reg < 6'd7)
        begin
            d = 6'(mk + 8'sd7); diff = d75;
        end
        else if (m_reg > 6'd7 && m_reg < 6'd21)
        begin
            base = ph_reg[2]; d = 6'(mk - 8'sd7); diff = d217;
        end
        else if (m_reg > 6'd43 && m_reg < 6'd57)
        begin
            base = ph_reg[0]; d = 6'(mk - 8'sd43); diff = d5743;
        end
        else if (m_reg > 6'd21 && m_reg < 6'd29)
        begin
            base = ph_reg[3]; d = 6'(mk - 8'sd21); diff = d217;
        end
        else if (m_reg > 6'd35 && m_reg < 6'd43)
        begin
            base = ph_reg[0]; d = 6'(mk - 8'sd43); diff = d5743;
        end
        else if (m_reg == 6'd7)
        begin
            base = ph_reg[2];
        end
        else if (m_reg == 6'd21)
        begin
            base = ph_reg[3];
        end
        else if (m_reg == 6'd43)
        begin
            base = ph_reg[0];
        end
    end

    // divide by span, rounded away from zero
    logic [22:0] mag;
    logic [21:0] div_a;
    logic [42:0] dprod;
    always_comb
    begin
        mag   = num_reg[22] ? 23'(-num_reg) : 23'(num_reg);
        div_a = 22'(mag + 23'd7);
        dprod = 43'(div_a) * 43'(DIV_RECIP);
    end

    // correction, wrap and fold, rotation setup
    logic [21:0] rem;
    logic [17:0] q;
    logic signed [19:0] phi, w;
    logic signed [15:0] ang;
    logic signed [CORDIC_W-1:0] rx0, ry0;
    always_comb
    begin
        rem = div_a_reg - (22'({div_q_reg, 4'b0}) - 22'({div_q_reg, 1'b0}));
        q   = (rem >= 22'(SPAN)) ? div_q_reg + 18'd1 : div_q_reg;
        phi = neg_reg ? 20'(base_reg) - 20'(q) : 20'(base_reg) + 20'(q);
        w   = 20'sd8192 - phi;
        ang = $signed({2'b0, w[13:0]}) - 16'sd8192;
        rx0 = CORDIC_W'(smp_re_reg) <<< 8;
        ry0 = CORDIC_W'(smp_im_reg) <<< 8;
        if (ang > HALF_PI_Q)
        begin
            rx0 = -rx0; ry0 = -ry0; ang = ang - PI_Q;
        end
        else if (ang < -HALF_PI_Q)
        begin
            rx0 = -rx0; ry0 = -ry0; ang = ang + PI_Q;
        end
    end

    // gain removal and saturation
    logic signed [43:0] gx, gy;
    logic signed [20:0] ox, oy;
    logic signed [SAMPLE_W-1:0] sx, sy;
    always_comb
    begin
        gx = 44'(cor_x) * 44'sd19898 + 44'sd4194304;
        gy = 44'(cor_y) * 44'sd19898 + 44'sd4194304;
        ox = 21'(gx >>> 23);
        oy = 21'(gy >>> 23);
        sx = (ox > 21'sd32767) ? 16'sh7fff : (ox < -21'sd32768) ? 16'sh8000 : 16'(ox);
        sy = (oy > 21'sd32767) ? 16'sh7fff : (oy < -21'sd32768) ? 16'sh8000 : 16'(oy);
    end

    logic slot_free;
    assign slot_free = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        cor_start  = 1'b0;
        cor_vec    = 1'b0;
        cor_x_in   = vx0;
        cor_y_in   = vy0;
        cor_z_in   = '0;
        req.pop    = 1'b0;
        req.busy   = (state_reg != ST_IDLE);
        req.rd_addr = m_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job.valid)
                begin
                    req.pop    = 1'b1;
                    state_next = ST_POL;
                end
            end
            ST_POL:    state_next = ST_RD_PIL;
            ST_RD_PIL:
            begin
                req.rd_addr = pilot_bin(l_reg);
                state_next  = ST_VEC;
            end
            ST_VEC:
            begin
                if (zero_vec)
                begin
                    state_next = (l_reg == 2'd3) ? ST_UNWRAP : ST_RD_PIL;
                end
                else
                begin
                    cor_start = 1'b1;
                    cor_vec   = 1'b1;
                    if (vx0 < 0)
                    begin
                        cor_x_in = -vx0;
                        cor_y_in = -vy0;
                        cor_z_in = (vy0 >= 0) ? PI_Q : -PI_Q;
                    end
                    state_next = ST_VEC_RUN;
                end
            end
            ST_VEC_RUN:
            begin
                if (cor_done)
                begin
                    state_next = (l_reg == 2'd3) ? ST_UNWRAP : ST_RD_PIL;
                end
            end
            ST_UNWRAP: state_next = ST_RD_BIN;
            ST_RD_BIN: state_next = ST_MUL;
            ST_MUL:    state_next = ST_DIV;
            ST_DIV:    state_next = ST_FIX;
            ST_FIX:
            begin
                cor_start  = 1'b1;
                cor_x_in   = rx0;
                cor_y_in   = ry0;
                cor_z_in   = ang;
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                if (cor_done)
                begin
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:   state_next = ST_OUT;
            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = (m_reg == LAST_BIN) ? ST_IDLE : ST_RD_BIN;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < 4; s++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    hist_reg[s][l] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // symbol zero restarts that stream's history
            if (state_reg == ST_POL && sym_reg == 16'd0)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    hist_reg[stream_reg][l] <= '0;
                end
            end
            if (state_reg == ST_UNWRAP)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    hist_reg[stream_reg][l] <= unw[l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                stream_reg <= job.stream;
                sym_reg    <= job.sym;
            end
            ST_POL:
            begin
                pol_neg_reg <= !POLARITY[pr[6:0]];
                n_idx_reg   <= 2'(n_cl - 3'd1);
                row_reg     <= ({1'b0, stream_reg} < n_cl) ? stream_reg : 2'(n_cl - 3'd1);
                l_reg       <= 2'd0;
            end
            ST_VEC:
            begin
                if (zero_vec)
                begin
                    raw_reg[l_reg] <= '0;
                    l_reg          <= l_reg + 2'd1;
                end
            end
            ST_VEC_RUN:
            begin
                if (cor_done)
                begin
                    raw_reg[l_reg] <= (cor_z > PI_Q) ? PI_Q : (cor_z < -PI_Q) ? -PI_Q : cor_z;
                    l_reg          <= l_reg + 2'd1;
                end
            end
            ST_UNWRAP:
            begin
                for (int l = 0; l < 4; l++)
                begin
                    ph_reg[l] <= unw[l];
                end
                m_reg <= FIRST_BIN;
            end
            ST_MUL:
            begin
                smp_re_reg <= rd_re;
                smp_im_reg <= rd_im;
                num_reg    <= 23'(d) * 23'(diff);
                base_reg   <= base;
            end
            ST_DIV:
            begin
                div_a_reg <= div_a;
                div_q_reg <= dprod[DIV_SHIFT +: 18];
                neg_reg   <= num_reg[22];
            end
            ST_GAIN:
            begin
                res_re_reg <= sx;
                res_im_reg <= sy;
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    out_stream_reg <= stream_reg;
                    out_bin_reg    <= m_reg;
                    out_re_reg     <= res_re_reg;
                    out_im_reg     <= res_im_reg;
                    out_last_reg   <= (m_reg == LAST_BIN);
                    m_reg          <= (m_reg == GAP_LAST) ? GAP_NEXT : m_reg + 6'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.out_stream = out_stream_reg;
    assign out_ch.out_bin    = out_bin_reg;
    assign out_ch.out_re     = out_re_reg;
    assign out_ch.out_im     = out_im_reg;
    assign out_ch.last       = out_last_reg;

endmodule

// File: test/ppt_tracker_checker.sv
// ----------------------------------------------------------------------------
// ppt_tracker_checker
// Watches the bin and corrected-bin channels, predicts the corrected bins of
// each symbol and compares them field by field in order of arrival.
// ----------------------------------------------------------------------------
module ppt_tracker_checker import ppt_pkg::*;
#(
    parameter int MAX_STREAMS  = MAX_STREAMS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    ppt_in_if          in_ch,
    ppt_out_if         out_ch,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_wr_data,
    output int         err_count,
    output int         pending
);

    typedef struct {
        logic [1:0]         stream;
        logic [BIN_W-1:0]   bin;
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               last;
    } corr_bin_t;

    corr_bin_t          corr_q[$];
    logic signed [15:0] buf_re[64];
    logic signed [15:0] buf_im[64];
    int                 hist[4][4];
    logic [2:0]         streams_reg;

    function automatic int pilot_phase(longint xi, longint yi);
        longint x, y, z, dx, dy;
        x = xi * 256;
        y = yi * 256;
        z = 0;
        if (xi == 0 && yi == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 8192 : -8192;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
            end
        end
        if (z > 8192) z = 8192;
        if (z < -8192) z = -8192;
        return int'(z);
    endfunction

    function automatic logic signed [15:0] sat16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return 16'(v);
    endfunction

    function automatic int div_span(int num);
        return (num + (num >= 0 ? 7 : -7)) / 14;
    endfunction

    // linear phase between pilots 7, 21, 43, 57
    function automatic int bin_phase(int p7, int p21, int p43, int p57, int m);
        if (m > 57) return p57 + div_span((m - 57) * (p7 - p57));
        if (m < 7) return p57 + div_span((m + 7) * (p7 - p57));
        if (m > 7 && m < 21) return p7 + div_span((m - 7) * (p21 - p7));
        if (m > 43 && m < 57) return p43 + div_span((m - 43) * (p57 - p43));
        if (m > 21 && m < 29) return p21 + div_span((m - 21) * (p21 - p7));
        if (m > 35 && m < 43) return p43 - div_span((43 - m) * (p57 - p43));
        if (m == 7) return p7;
        if (m == 21) return p21;
        if (m == 43) return p43;
        if (m == 57) return p57;
        return 0;
    endfunction

    task automatic derotate(input int m, input int phi, output logic signed [15:0] ore,
                            output logic signed [15:0] oim);
        int     u;
        longint a, x, y, dx, dy;
        u = (8192 - phi) & 16383;
        a = longint'(u) - 8192;
        x = longint'(buf_re[m]) * 256;
        y = longint'(buf_im[m]) * 256;
        if (a > 4096)
        begin
            x = -x; y = -y; a -= 8192;
        end
        else if (a < -4096)
        begin
            x = -x; y = -y; a += 8192;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (a >= 0)
            begin
                x -= dx; y += dy; a -= longint'(ATAN_TAB[i]);
            end
            else
            begin
                x += dx; y -= dy; a += longint'(ATAN_TAB[i]);
            end
        end
        ore = sat16((x * GAIN_Q15 + (64'sd1 <<< 22)) >>> 23);
        oim = sat16((y * GAIN_Q15 + (64'sd1 <<< 22)) >>> 23);
    endtask

    task automatic close_symbol(input logic [1:0] strm, input logic [15:0] sym);
        int        n, row, sgn, pol, raw[4], ph[4];
        bit        same_sign;
        logic [5:0] pb;
        corr_bin_t c;
        n = int'(streams_reg);
        if (n < 1) n = 1;
        if (n > MAX_STREAMS) n = MAX_STREAMS;
        if (n > 4) n = 4;
        row = (int'(strm) < n) ? int'(strm) : n - 1;
        pol = POLARITY[(int'(sym) + 2) % 127] ? 1 : -1;
        if (sym == 0)
            for (int l = 0; l < 4; l++) hist[strm][l] = 0;
        for (int l = 0; l < 4; l++)
        begin
            sgn = PATTERN_NEG[(n - 1) * 16 + row * 4 + ((int'(sym) + l) & 3)] ? -pol : pol;
            pb = pilot_bin(2'(l));
            raw[l] = pilot_phase(longint'(buf_re[pb]) * sgn, longint'(buf_im[pb]) * sgn);
        end
        same_sign = (raw[0] > 0 && raw[1] > 0 && raw[2] > 0 && raw[3] > 0) ||
                    (raw[0] < 0 && raw[1] < 0 && raw[2] < 0 && raw[3] < 0);
        for (int l = 0; l < 4; l++)
        begin
            ph[l] = raw[l];
            if (!same_sign && hist[strm][l] > 4096 && ph[l] < -4096) ph[l] += 16384;
            if (!same_sign && hist[strm][l] < -4096 && ph[l] > 4096) ph[l] -= 16384;
            hist[strm][l] = ph[l];
        end
        for (int m = 1; m < 64; m++)
        begin
            if (m > 28 && m < 36)
                continue;
            c.stream = strm;
            c.bin    = 6'(m);
            c.last   = (m == 63);
            derotate(m, bin_phase(ph[2], ph[3], ph[0], ph[1], m), c.re, c.im);
            corr_q.push_back(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        corr_bin_t e;
        int        errs;
        errs = 0;
        if (!rst_n)
        begin
            streams_reg = 3'd1;
            for (int s = 0; s < 4; s++)
                for (int l = 0; l < 4; l++) hist[s][l] = 0;
            err_count <= 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                streams_reg = cfg_wr_data;
            if (out_ch.valid && out_ch.ready)
            begin
                if (corr_q.size() == 0)
                begin
                    $error("corrected bin %0d with none expected", out_ch.out_bin);
                    errs++;
                end
                else
                begin
                    e = corr_q.pop_front();
                    if (out_ch.out_stream !== e.stream)
                    begin
                        $error("out_stream expected %0d got %0d", e.stream, out_ch.out_stream);
                        errs++;
                    end
                    if (out_ch.out_bin !== e.bin)
                    begin
                        $error("out_bin expected %0d got %0d", e.bin, out_ch.out_bin);
                        errs++;
                    end
                    if (out_ch.out_re !== e.re)
                    begin
                        $error("out_re expected %0d got %0d", e.re, out_ch.out_re);
                        errs++;
                    end
                    if (out_ch.out_im !== e.im)
                    begin
                        $error("out_im expected %0d got %0d", e.im, out_ch.out_im);
                        errs++;
                    end
                    if (out_ch.last !== e.last)
                    begin
                        $error("last expected %0d got %0d", e.last, out_ch.last);
                        errs++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                buf_re[in_ch.bin] = in_ch.sample_re;
                buf_im[in_ch.bin] = in_ch.sample_im;
                if (in_ch.bin == LAST_BIN)
                    close_symbol(in_ch.stream, in_ch.symbol_number);
            end
            err_count <= err_count + errs;
            pending   <= corr_q.size();
        end
    end

endmodule

// File: test/ofdm_pilot_phase_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// ofdm_pilot_phase_tracker_core_tb
// Feeds whole symbols and stray bins to the pilot phase tracker under random
// handshake gaps and num_streams settings 0, 1, 2, 3, 4 and 7; a checker
// beside the block predicts each corrected bin and counts mismatches.
// ----------------------------------------------------------------------------
module ofdm_pilot_phase_tracker_core_tb import ppt_pkg::*;;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [2:0] cfg_wr_data;
    int         err_count;
    int         pending;
    int         tx_gap_max;
    int         rx_gap_max;
    int         symbols_sent;
    int         stray_sent;
    logic [15:0] sym_cnt[4];

    ppt_in_if  in_ch();
    ppt_out_if out_ch();

    ofdm_pilot_phase_tracker_core uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    ppt_tracker_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .err_count   (err_count),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #3000000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: hold off for a long stretch first so the block fills up and
    // stalls its input, then stall a random number of cycles before each item.
    initial
    begin
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        repeat (2500) @(posedge clk);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_gap_max);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge clk); while (!out_ch.valid);
        end
    end

    // Offer one bin, waiting a random gap first; valid stays high on return.
    task automatic send_bin(input logic [1:0] strm, input logic [5:0] b,
                            input logic [15:0] re, input logic [15:0] im,
                            input logic [15:0] sym);
        int gap;
        gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.stream        <= strm;
        in_ch.bin           <= b;
        in_ch.sample_re     <= re;
        in_ch.sample_im     <= im;
        in_ch.symbol_number <= sym;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // Send bins 0..63. Sample kind: 0 random, 1 full scale positive,
    // 2 full scale negative, 3 zero pilots, 4 small values.
    // Bin 63 may carry another stream to exercise interleaving.
    task automatic send_symbol(input logic [1:0] strm, input logic [1:0] strm63,
                               input logic [15:0] sym, input int kind);
        logic [15:0] re, im;
        for (int b = 0; b < 64; b++)
        begin
            case (kind)
                1:       begin re = 16'h7fff; im = 16'h7fff; end
                2:       begin re = 16'h8000; im = 16'h8000; end
                3:       begin
                             re = 16'($urandom); im = 16'($urandom);
                             if (b == 7 || b == 21 || b == 43 || b == 57)
                             begin
                                 re = 16'h0; im = 16'h0;
                             end
                         end
                4:       begin
                             re = 16'($signed($urandom_range(0, 64)) - 32);
                             im = 16'($signed($urandom_range(0, 64)) - 32);
                         end
                default: begin re = 16'($urandom); im = 16'($urandom); end
            endcase
            send_bin((b == 63) ? strm63 : strm, 6'(b), re, im, sym);
        end
        symbols_sent++;
    endtask

    // Pick the next symbol number for a stream: usually the next count,
    // sometimes zero to clear history, sometimes any value.
    function automatic logic [15:0] next_sym(input logic [1:0] strm);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) sym_cnt[strm] = 16'd0;
        else if (r == 1) sym_cnt[strm] = 16'($urandom);
        else if (r == 2) sym_cnt[strm] = 16'hffff;
        else sym_cnt[strm] = sym_cnt[strm] + 16'd1;
        return sym_cnt[strm];
    endfunction

    // Drain, let the block settle, then load num_streams.
    task automatic set_streams(input logic [2:0] v);
        wait (pending == 0);
        repeat (150) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [2:0]  stream_settings[6];
        logic [1:0]  s;
        logic [15:0] sym;
        stream_settings = '{3'd2, 3'd4, 3'd0, 3'd7, 3'd3, 3'd1};
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.stream        = '0;
        in_ch.bin           = '0;
        in_ch.sample_re     = '0;
        in_ch.sample_im     = '0;
        in_ch.symbol_number = '0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        tx_gap_max          = 0;
        rx_gap_max          = 14;
        symbols_sent        = 0;
        stray_sent          = 0;
        for (int i = 0; i < 4; i++) sym_cnt[i] = 16'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: back to back with no gaps while the receiver holds off,
        // full scale, zero pilots, history clear at symbol zero.
        send_symbol(2'd0, 2'd0, 16'd0, 1);
        send_symbol(2'd3, 2'd3, 16'd0, 3);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        // Sender waits out every expected result before going on.
        wait (pending == 0);
        @(posedge clk);

        for (int p = 0; p < 6; p++)
        begin
            set_streams(stream_settings[p]);
            tx_gap_max = (p % 2 == 0) ? 14 : 0;
            rx_gap_max = (p % 3 == 0) ? 0 : 14;
            s = 2'($urandom);
            sym = next_sym(s);
            // occasionally close the symbol under another stream
            send_symbol(s, ($urandom_range(0, 3) == 0) ? 2'($urandom) : s, sym,
                        (p == 1) ? 2 : ((p == 4) ? 4 : 0));
            // stray bins in any order; a stray bin 63 closes a symbol too
            for (int k = 0; k < 4; k++)
            begin
                send_bin(2'($urandom), 6'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom));
                stray_sent++;
            end
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end

        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (300) @(posedge clk);
        $display("Ran %0d full symbols and %0d stray bins over num_streams 0..7 settings,",
                 symbols_sent, stray_sent);
        $display("with back-pressure and random gaps on both channels.");
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/ppt_pkg.sv
rtl/core/ppt_in_if.sv
rtl/core/ppt_out_if.sv
rtl/core/ppt_front.sv
rtl/core/ppt_cordic.sv
rtl/core/ppt_back.sv
rtl/core/ofdm_pilot_phase_tracker_core.sv
test/ppt_tracker_checker.sv
test/ofdm_pilot_phase_tracker_core_tb.sv
